// ----- sv/psbd_pkg.sv -----
`timescale 1ns / 1ps

package psbd_pkg;

	localparam int DATA_W = 32;
	localparam int CNT_W  = 8;
	localparam int CAP_W  = 8;

	localparam logic MODE_PUSH = 1'b0;
	localparam logic MODE_POP  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOT_INIT = 2'd1,
		ST_FULL     = 2'd2,
		ST_EMPTY    = 2'd3
	} psbd_status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} psbd_state_t;

	// controller -> datapath
	typedef struct packed {
		logic start;
		logic load;
	} psbd_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free;
	} psbd_sts_t;

endpackage

// ----- sv/psbd_req_if.sv -----
`timescale 1ns / 1ps

interface psbd_req_if;
	logic                                valid;
	logic                                ready;
	logic                                mode;
	logic signed [psbd_pkg::DATA_W-1:0]  data_in;

	modport source (output valid, output mode, output data_in, input ready);
	modport sink   (input valid, input mode, input data_in, output ready);
endinterface

// ----- sv/psbd_rsp_if.sv -----
`timescale 1ns / 1ps

interface psbd_rsp_if;
	logic                                valid;
	logic                                ready;
	psbd_pkg::psbd_status_t              status;
	logic signed [psbd_pkg::DATA_W-1:0]  data_out;
	logic [psbd_pkg::CNT_W-1:0]          occupancy;

	modport source (output valid, output status, output data_out, output occupancy,
		input ready);
	modport sink   (input valid, input status, input data_out, input occupancy,
		output ready);
endinterface

// ----- sv/parity_steered_bounded_deque_core.sv -----
`timescale 1ns / 1ps

// Bounded deque of signed 32-bit words, held in a ring buffer of DEPTH entries.
// Channels: req (sink) carries mode and data_in; rsp (source) carries
// status, data_out and occupancy. Both move an item on valid && ready.
// A push sends odd non-negative words to the front and all others to the
// rear; a pop returns the front word. Every request item yields one result.
// cfg_we/cfg_wdata write the capacity register; 0 leaves the deque not
// initialised, values above DEPTH act as DEPTH. Write it only while idle.
// An accepted item's status, count and pop data are registered first, then
// moved into the output register once it frees. A new item is taken only
// after the last one's result has moved to the output register.
// Reset clears capacity, head and count; no memory clearing pass is needed.
// When rsp stalls, the output register holds its item; the block still
// accepts one more item and holds its finished result until the output
// register frees, with req.ready low meanwhile.
module parity_steered_bounded_deque_core #(
	parameter int DEPTH = 128
) (
	input  logic                        clk,
	input  logic                        arst_n,
	psbd_req_if.sink                    req,
	psbd_rsp_if.source                  rsp,
	input  logic                        cfg_we,
	input  logic [psbd_pkg::CAP_W-1:0]  cfg_wdata
);
	import psbd_pkg::*;

	psbd_cmd_t cmd;
	psbd_sts_t sts;

	// sequencer: accept in idle, deliver result in exec
	psbd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// pointers, capacity, entry memory and output register
	psbd_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.cmd           (cmd),
		.sts           (sts),
		.in_mode       (req.mode),
		.in_data       (req.data_in),
		.out_valid     (rsp.valid),
		.out_ready     (rsp.ready),
		.out_status    (rsp.status),
		.out_data      (rsp.data_out),
		.out_occupancy (rsp.occupancy)
	);

endmodule

// ----- sv/psbd_ctrl.sv -----
`timescale 1ns / 1ps

module psbd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  psbd_pkg::psbd_sts_t sts,
	output psbd_pkg::psbd_cmd_t cmd
);
	import psbd_pkg::*;

	psbd_state_t state_q;
	psbd_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		cmd.start = 1'b0;
		cmd.load  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready  = 1'b1;
				cmd.start = in_valid;
			end
			S_EXEC: begin
				cmd.load = sts.out_free;
			end
			default: ;
		endcase
	end

endmodule

// ----- sv/psbd_dp.sv -----
`timescale 1ns / 1ps

module psbd_dp #(
	parameter int DEPTH = 128
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [psbd_pkg::CAP_W-1:0]          cfg_wdata,
	input  psbd_pkg::psbd_cmd_t                 cmd,
	output psbd_pkg::psbd_sts_t                 sts,
	input  logic                                in_mode,
	input  logic signed [psbd_pkg::DATA_W-1:0]  in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output psbd_pkg::psbd_status_t              out_status,
	output logic signed [psbd_pkg::DATA_W-1:0]  out_data,
	output logic [psbd_pkg::CNT_W-1:0]          out_occupancy
);
	import psbd_pkg::*;

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SW = ((IW > CNT_W) ? IW : CNT_W) + 1;
	localparam logic [SW-1:0] DEPTH_SW = SW'(DEPTH);
	localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
	// effective capacity ceiling: the register cannot exceed 255
	localparam logic [CAP_W:0] DEPTH_CAP = (DEPTH > 255) ? (CAP_W+1)'(256) : (CAP_W+1)'(DEPTH);

	logic [CAP_W-1:0] cap_q;
	logic [IW-1:0]    head_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_q;

	psbd_status_t     status_s1;
	logic             pop_ok_s1;
	logic [CNT_W-1:0] cnt_s1;

	logic             out_valid_q;
	psbd_status_t     out_status_q;
	logic [DATA_W-1:0] out_data_q;
	logic [CNT_W-1:0] out_occ_q;

	logic [CAP_W:0]   limit;
	logic             full;
	logic             to_front;
	logic [SW-1:0]    tail_sum;
	logic [IW-1:0]    tail_idx;
	logic [IW-1:0]    head_dec;
	logic [IW-1:0]    head_inc;
	psbd_status_t     status_d;
	logic             mem_we;
	logic             mem_re;
	logic [IW-1:0]    waddr;
	logic [IW-1:0]    head_d;
	logic [CNT_W-1:0] cnt_d;

	always_comb begin
		limit    = ({1'b0, cap_q} > DEPTH_CAP) ? DEPTH_CAP : {1'b0, cap_q};
		full     = {1'b0, cnt_q} >= limit;
		to_front = in_data[0] & ~in_data[DATA_W-1];
		tail_sum = SW'(head_q) + SW'(cnt_q);
		if (tail_sum >= DEPTH_SW) tail_sum = tail_sum - DEPTH_SW;
		tail_idx = tail_sum[IW-1:0];
		head_dec = (head_q == '0) ? LAST_IDX : head_q - 1'b1;
		head_inc = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
	end

	always_comb begin
		status_d = ST_OK;
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		waddr    = head_q;
		head_d   = head_q;
		cnt_d    = cnt_q;
		priority if (cap_q == '0) begin
			status_d = ST_NOT_INIT;
		end else if (in_mode == MODE_PUSH) begin
			if (full) begin
				status_d = ST_FULL;
			end else begin
				mem_we = 1'b1;
				cnt_d  = cnt_q + 1'b1;
				priority if (cnt_q == '0) begin
					waddr = head_q;
				end else if (to_front) begin
					waddr  = head_dec;
					head_d = head_dec;
				end else begin
					waddr = tail_idx;
				end
			end
		end else begin
			if (cnt_q == '0) begin
				status_d = ST_EMPTY;
			end else begin
				mem_re = 1'b1;
				head_d = head_inc;
				cnt_d  = cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= '0;
			head_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (cfg_we) cap_q <= cfg_wdata;
			if (cmd.start) begin
				head_q <= head_d;
				cnt_q  <= cnt_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start && mem_we) mem[waddr] <= in_data;
	end

	always_ff @(posedge clk) begin
		if (cmd.start && mem_re) rd_q <= mem[head_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			status_s1 <= status_d;
			pop_ok_s1 <= mem_re;
			cnt_s1    <= cnt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_status_q <= status_s1;
			out_data_q   <= pop_ok_s1 ? rd_q : '0;
			out_occ_q    <= cnt_s1;
		end
	end

	assign sts.out_free   = ~out_valid_q | out_ready;
	assign out_valid      = out_valid_q;
	assign out_status     = out_status_q;
	assign out_data       = out_data_q;
	assign out_occupancy  = out_occ_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, cnt_q} <= DEPTH_CAP)
		else $error("entry count beyond storage");

	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		SW'(head_q) < DEPTH_SW)
		else $error("head index out of range");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start && mem_we |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("accepted push did not advance count");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load && status_s1 == ST_EMPTY |=> out_data_q == '0)
		else $error("empty pop returned nonzero data");

endmodule

// ----- tb/parity_steered_bounded_deque_core_tb.sv -----
`timescale 1ns / 1ps

module parity_steered_bounded_deque_core_tb;

	import psbd_pkg::*;

	localparam int DEPTH        = 128;
	localparam int HEAD_W       = $clog2(DEPTH);
	localparam int HOLD_CYCLES  = 200;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 400000;

	typedef logic signed [DATA_W-1:0] word_t;

	typedef struct {
		logic  mode;
		word_t data_in;
	} deque_request_t;

	typedef struct {
		psbd_status_t      status;
		word_t             data_out;
		logic [CNT_W-1:0]  occupancy;
	} deque_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CAP_W-1:0] cfg_wdata;

	psbd_req_if req_ch ();
	psbd_rsp_if rsp_ch ();

	parity_steered_bounded_deque_core #(
		.DEPTH(DEPTH)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.rsp      (rsp_ch),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// Requests waiting to be offered, and results the deque owes us, oldest first.
	deque_request_t request_backlog[$];
	deque_result_t  owed_results[$];

	// Shadow copy of the deque: ring storage, front slot, fill level, capacity.
	word_t             shadow_store [DEPTH];
	logic [HEAD_W-1:0] shadow_head;
	logic [CNT_W-1:0]  shadow_count;
	logic [CAP_W-1:0]  shadow_cap;

	// Idling knobs, percent of cycles; changed only away from the rising edge.
	int unsigned send_idle_pct;
	int unsigned rsp_stall_pct;

	// Long receiver hold-off: bump hold_requests to start one.
	int unsigned hold_requests;
	int unsigned hold_served;
	int unsigned hold_left;

	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;
	int unsigned items_accepted = 0;
	int unsigned results_checked = 0;
	int unsigned status_tally [4] = '{default: 0};

	deque_request_t next_request;
	deque_result_t  owed;
	deque_result_t  due;

	// Apply one request to the shadow deque and return the result it must produce.
	function automatic deque_result_t apply_request(logic mode, word_t word);
		deque_result_t     res;
		logic [CNT_W:0]    limit;
		logic [HEAD_W-1:0] slot;
		res.status   = ST_OK;
		res.data_out = '0;
		limit = (shadow_cap > DEPTH) ? (CNT_W+1)'(DEPTH) : (CNT_W+1)'(shadow_cap);
		if (shadow_cap == '0) begin
			res.status = ST_NOT_INIT;
		end else if (mode == MODE_PUSH) begin
			if ({1'b0, shadow_count} >= limit) begin
				res.status = ST_FULL;
			end else begin
				if (shadow_count == '0) begin
					shadow_store[shadow_head] = word;
				end else if (word[0] && !word[DATA_W-1]) begin
					// odd and non-negative: grow at the front
					shadow_head = shadow_head - 1'b1;
					shadow_store[shadow_head] = word;
				end else begin
					slot = shadow_head + shadow_count[HEAD_W-1:0];
					shadow_store[slot] = word;
				end
				shadow_count = shadow_count + 1'b1;
			end
		end else begin
			if (shadow_count == '0) begin
				res.status = ST_EMPTY;
			end else begin
				res.data_out = shadow_store[shadow_head];
				shadow_head  = shadow_head + 1'b1;
				shadow_count = shadow_count - 1'b1;
			end
		end
		res.occupancy = shadow_count;
		return res;
	endfunction

	// Request driver: follow capacity writes, predict each accepted item,
	// then offer the next pending item unless this cycle is an idle one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid   <= 1'b0;
			req_ch.mode    <= MODE_PUSH;
			req_ch.data_in <= '0;
			shadow_head  = '0;
			shadow_count = '0;
			shadow_cap   = '0;
		end else begin
			if (cfg_we)
				shadow_cap = cfg_wdata;
			if (req_ch.valid && req_ch.ready) begin
				owed = apply_request(req_ch.mode, req_ch.data_in);
				owed_results.push_back(owed);
				status_tally[owed.status]++;
				items_accepted++;
			end
			// Hold the offered item until it is taken.
			if (!req_ch.valid || req_ch.ready) begin
				if (request_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_request = request_backlog.pop_front();
					req_ch.valid   <= 1'b1;
					req_ch.mode    <= next_request.mode;
					req_ch.data_in <= next_request.data_in;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Hold-off counter: keep the result channel stalled after each hold request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left   <= 0;
			hold_served <= 0;
		end else if (hold_served != hold_requests) begin
			hold_left   <= HOLD_CYCLES;
			hold_served <= hold_requests;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Result monitor: check each accepted result against the oldest owed one,
	// then pick the next ready level.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				results_checked++;
				if (owed_results.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: result with none owed: status %0d data %0d occupancy %0d",
							$realtime, rsp_ch.status, rsp_ch.data_out, rsp_ch.occupancy);
					mismatches++;
				end else begin
					due = owed_results.pop_front();
					if (rsp_ch.status !== due.status || rsp_ch.data_out !== due.data_out ||
							rsp_ch.occupancy !== due.occupancy) begin
						if (mismatches < 10)
							$display("%0t: mismatch: expected status %0d data %0d occ %0d, got %0d %0d %0d",
								$realtime, due.status, due.data_out, due.occupancy,
								rsp_ch.status, rsp_ch.data_out, rsp_ch.occupancy);
						mismatches++;
					end
				end
			end
			rsp_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= rsp_stall_pct);
		end
	end

	// Watchdog: end a stuck run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results still owed",
				cycle_count, owed_results.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic queue_item(logic mode, word_t word);
		deque_request_t r;
		r.mode    = mode;
		r.data_in = word;
		request_backlog.push_back(r);
	endtask

	// Wait until every item went in and every owed result came back.
	task automatic wait_drained();
		while (request_backlog.size() != 0 || req_ch.valid || owed_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(logic [CAP_W-1:0] value);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic set_idling(int unsigned send_pct, int unsigned stall_pct);
		@(negedge clk);
		send_idle_pct = send_pct;
		rsp_stall_pct = stall_pct;
	endtask

	// Mix of wide random words, small values around zero and sign/parity extremes.
	function automatic word_t random_word();
		int v;
		case ($urandom_range(4))
			0: begin
				v = $urandom_range(16);
				return word_t'(v - 8);
			end
			1: begin
				case ($urandom_range(3))
					0: return 32'sh8000_0000;
					1: return 32'sh7FFF_FFFF;
					2: return 32'sh8000_0001;
					default: return 32'shFFFF_FFFF;
				endcase
			end
			default: return word_t'($urandom);
		endcase
	endfunction

	// Random pushes and pops; the push share flips between fill_pct and its
	// complement every stretch items, so the fill level sweeps full and empty.
	task automatic queue_random(int n, int unsigned fill_pct, int stretch);
		int unsigned pct;
		for (int i = 0; i < n; i++) begin
			pct = ((i / stretch) % 2 == 0) ? fill_pct : 100 - fill_pct;
			if ($urandom_range(99) < pct)
				queue_item(MODE_PUSH, random_word());
			else
				queue_item(MODE_POP, '0);
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_wdata      = '0;
		send_idle_pct  = 0;
		rsp_stall_pct  = 0;
		hold_requests  = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Not initialised: capacity still zero after reset.
		queue_item(MODE_PUSH, 32'sd5);
		queue_item(MODE_POP, '0);

		// Capacity 3: empty pop, parity steering, full push, drain in front order.
		write_capacity(8'd3);
		queue_item(MODE_POP, '0);
		queue_item(MODE_PUSH, 32'sd1);
		queue_item(MODE_PUSH, -32'sd1);
		queue_item(MODE_PUSH, 32'sh7FFF_FFFF);
		queue_item(MODE_PUSH, 32'sh8000_0000);
		repeat (4) queue_item(MODE_POP, '0);

		// Shrink capacity below the fill level: pushes see full, pops still work.
		write_capacity(8'd5);
		queue_item(MODE_PUSH, 32'sd0);
		queue_item(MODE_PUSH, -32'sd2);
		queue_item(MODE_PUSH, 32'sd3);
		queue_item(MODE_PUSH, -32'sd3);
		queue_item(MODE_PUSH, 32'sh7FFF_FFFE);
		write_capacity(8'd2);
		queue_item(MODE_PUSH, 32'sd7);
		queue_item(MODE_POP, '0);
		queue_item(MODE_POP, '0);

		// Back to not initialised with entries held, then a capacity of one.
		write_capacity(8'd0);
		queue_item(MODE_PUSH, 32'sd9);
		queue_item(MODE_POP, '0);
		write_capacity(8'd1);
		repeat (4) queue_item(MODE_POP, '0);

		// Small capacity, full rate both ways.
		write_capacity(8'd7);
		set_idling(0, 0);
		queue_random(300, 70, 25);

		// Capacity beyond the store saturates: fill to the top, then drain.
		write_capacity(8'd255);
		set_idling(83, 0);
		queue_random(250, 85, 250);
		queue_random(150, 10, 150);

		// Exactly the store size, receiver stalling; pause the sender midway.
		write_capacity(8'd128);
		set_idling(0, 83);
		queue_random(150, 75, 60);
		wait_drained();
		queue_random(150, 60, 40);

		// Single entry, both sides idling.
		write_capacity(8'd1);
		set_idling(37, 37);
		queue_random(200, 50, 20);

		// Long receiver hold-off while the sender keeps offering.
		write_capacity(8'd100);
		set_idling(0, 0);
		hold_requests = hold_requests + 1;
		queue_random(300, 65, 80);

		// Turn the deque off with entries held, then on again and keep going.
		write_capacity(8'd0);
		set_idling(37, 37);
		queue_random(50, 50, 50);
		write_capacity(8'd60);
		queue_random(250, 55, 50);

		while (request_backlog.size() != 0 || req_ch.valid)
			@(posedge clk);
		while (owed_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d requests over capacities 0..255 with four idling mixes, %0d results checked",
			items_accepted, results_checked);
		$display("Result mix: %0d ok, %0d not initialised, %0d full, %0d empty; %0d failures",
			status_tally[ST_OK], status_tally[ST_NOT_INIT], status_tally[ST_FULL],
			status_tally[ST_EMPTY], mismatches);
		if (mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
sv/psbd_pkg.sv
sv/psbd_req_if.sv
sv/psbd_rsp_if.sv
sv/psbd_ctrl.sv
sv/psbd_dp.sv
sv/parity_steered_bounded_deque_core.sv
tb/parity_steered_bounded_deque_core_tb.sv
